// ===== rtl/core/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg: shared types and widths of the rational arithmetic unit
// Operand and intermediate widths, opcode and status codes.
// ----------------------------------------------------------------------------
package rau_pkg;

   localparam int OPERAND_WIDTH = 16;
   localparam int DEN_WIDTH     = OPERAND_WIDTH - 1;
   localparam int MUL_WIDTH     = OPERAND_WIDTH + 1;
   localparam int PROD_WIDTH    = 2 * MUL_WIDTH;
   localparam int NUM_WIDTH     = 2 * OPERAND_WIDTH + 1;
   localparam int MAG_WIDTH     = 2 * OPERAND_WIDTH;
   localparam int SHIFT_WIDTH   = $clog2(MAG_WIDTH + 1);
   localparam int COUNT_WIDTH   = $clog2(MAG_WIDTH);
   localparam int RES_NUM_WIDTH = 32;
   localparam int RES_DEN_WIDTH = 31;
   localparam int STATUS_WIDTH  = 2;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STAT_OK       = 2'd0,
      STAT_ZERO_DEN = 2'd1,
      STAT_DIV_ZERO = 2'd2
   } status_type;

endpackage

// ===== rtl/core/rational_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: signed fraction add, subtract, multiply, divide
// Cross-multiplies on one shared multiplier, reduces by a binary GCD and
// two restoring divisions that share one subtractor.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  opcode, num_a, den_a, num_b, den_b
//   rsp      out        rsp_valid/rsp_stall  res_num, res_den, status
//
// An item passes through the multiply steps, a setup step, the binary GCD
// steps and the division steps on the shared subtractor, plus an accept and
// a hand-off step.
// A zero denominator or a division by zero goes from acceptance straight to
// the hand-off, a zero numerator after the multiply and setup steps.
// req_stall is high from acceptance until the result moves to the output
// register; a held result on a stalled rsp does not block the next word.
// Synchronous reset clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit import rau_pkg::*; (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_opcode,
   input  logic signed [OPERAND_WIDTH-1:0] req_num_a,
   input  logic [DEN_WIDTH-1:0]            req_den_a,
   input  logic signed [OPERAND_WIDTH-1:0] req_num_b,
   input  logic [DEN_WIDTH-1:0]            req_den_b,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [RES_NUM_WIDTH-1:0] rsp_res_num,
   output logic [RES_DEN_WIDTH-1:0]        rsp_res_den,
   output logic [STATUS_WIDTH-1:0]         rsp_status
);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_MUL  = 6'b000010,
      S_PREP = 6'b000100,
      S_GCD  = 6'b001000,
      S_DIV  = 6'b010000,
      S_DONE = 6'b100000
   } state_type;

   state_type                      state_ff, state_in;
   opcode_type                     opcode_ff, opcode_in;
   logic signed [OPERAND_WIDTH-1:0] num_a_ff, num_a_in, num_b_ff, num_b_in;
   logic [DEN_WIDTH-1:0]           den_a_ff, den_a_in, den_b_ff, den_b_in;
   logic [1:0]                     step_ff, step_in;
   logic signed [PROD_WIDTH-1:0]   prod_ff, prod_in;
   logic signed [NUM_WIDTH-1:0]    n_ff, n_in, d_ff, d_in;
   logic                           neg_ff, neg_in;
   logic [MAG_WIDTH-1:0]           mag_ff, mag_in, dmag_ff, dmag_in;
   logic [MAG_WIDTH-1:0]           u_ff, u_in, v_ff, v_in;
   logic [SHIFT_WIDTH-1:0]         k_ff, k_in;
   logic [MAG_WIDTH-1:0]           rem_ff, rem_in, quo_ff, quo_in, qnum_ff, qnum_in;
   logic [COUNT_WIDTH-1:0]         div_cnt_ff, div_cnt_in;
   logic                           div_sel_ff, div_sel_in;
   logic signed [RES_NUM_WIDTH-1:0] res_num_ff, res_num_in;
   logic [RES_DEN_WIDTH-1:0]       res_den_ff, res_den_in;
   status_type                     res_status_ff, res_status_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [RES_NUM_WIDTH-1:0] rsp_num_ff, rsp_num_in;
   logic [RES_DEN_WIDTH-1:0]       rsp_den_ff, rsp_den_in;
   status_type                     rsp_status_ff, rsp_status_in;

   logic                           accept;
   logic signed [MUL_WIDTH-1:0]    mul_a, mul_b;
   logic signed [PROD_WIDTH-1:0]   mul_prod;
   logic signed [NUM_WIDTH-1:0]    prod_trunc;
   logic [NUM_WIDTH-1:0]           n_abs, d_abs;
   logic                           u_ge_v;
   logic [MAG_WIDTH+1:0]           sub_a, sub_b, sub_res;
   logic                           borrow;
   logic [MAG_WIDTH-1:0]           quo_next;
   logic signed [MAG_WIDTH:0]      qnum_sgn;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_res_num = rsp_num_ff;
   assign rsp_res_den = rsp_den_ff;
   assign rsp_status  = rsp_status_ff;

   // shared multiplier: operand pair chosen by step and opcode
   always_comb begin
      unique case (step_ff)
         2'd0: begin
            mul_a = $signed({num_a_ff[OPERAND_WIDTH-1], num_a_ff});
            mul_b = (opcode_ff == OP_MUL) ? $signed({num_b_ff[OPERAND_WIDTH-1], num_b_ff})
                                          : $signed({2'b00, den_b_ff});
         end
         2'd1: begin
            mul_a = $signed({num_b_ff[OPERAND_WIDTH-1], num_b_ff});
            mul_b = $signed({2'b00, den_a_ff});
         end
         default: begin
            mul_a = $signed({2'b00, den_a_ff});
            mul_b = (opcode_ff == OP_DIV) ? $signed({num_b_ff[OPERAND_WIDTH-1], num_b_ff})
                                          : $signed({2'b00, den_b_ff});
         end
      endcase
   end

   assign mul_prod   = mul_a * mul_b;
   assign prod_trunc = NUM_WIDTH'(prod_ff);

   assign n_abs = n_ff[NUM_WIDTH-1] ? NUM_WIDTH'(-n_ff) : NUM_WIDTH'(n_ff);
   assign d_abs = d_ff[NUM_WIDTH-1] ? NUM_WIDTH'(-d_ff) : NUM_WIDTH'(d_ff);

   // shared subtractor: GCD difference or division trial
   assign u_ge_v = (u_ff >= v_ff);
   always_comb begin
      if (state_ff == S_DIV) begin
         sub_a = {1'b0, rem_ff, quo_ff[MAG_WIDTH-1]};
         sub_b = {2'b00, v_ff};
      end else begin
         sub_a = {2'b00, (u_ge_v ? u_ff : v_ff)};
         sub_b = {2'b00, (u_ge_v ? v_ff : u_ff)};
      end
   end
   assign sub_res  = sub_a - sub_b;
   assign borrow   = sub_res[MAG_WIDTH+1];
   assign quo_next = {quo_ff[MAG_WIDTH-2:0], !borrow};
   assign qnum_sgn = neg_ff ? -$signed({1'b0, qnum_ff}) : $signed({1'b0, qnum_ff});

   always_comb begin
      state_in      = state_ff;
      opcode_in     = opcode_ff;
      num_a_in      = num_a_ff;
      den_a_in      = den_a_ff;
      num_b_in      = num_b_ff;
      den_b_in      = den_b_ff;
      step_in       = step_ff;
      prod_in       = prod_ff;
      n_in          = n_ff;
      d_in          = d_ff;
      neg_in        = neg_ff;
      mag_in        = mag_ff;
      dmag_in       = dmag_ff;
      u_in          = u_ff;
      v_in          = v_ff;
      k_in          = k_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      qnum_in       = qnum_ff;
      div_cnt_in    = div_cnt_ff;
      div_sel_in    = div_sel_ff;
      res_num_in    = res_num_ff;
      res_den_in    = res_den_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_num_in    = rsp_num_ff;
      rsp_den_in    = rsp_den_ff;
      rsp_status_in = rsp_status_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               opcode_in  = opcode_type'(req_opcode);
               num_a_in   = req_num_a;
               den_a_in   = req_den_a;
               num_b_in   = req_num_b;
               den_b_in   = req_den_b;
               step_in    = 2'd0;
               res_num_in = '0;
               res_den_in = RES_DEN_WIDTH'(1);
               priority if (req_den_a == '0 || req_den_b == '0) begin
                  res_status_in = STAT_ZERO_DEN;
                  state_in      = S_DONE;
               end else if (opcode_type'(req_opcode) == OP_DIV && req_num_b == '0) begin
                  res_status_in = STAT_DIV_ZERO;
                  state_in      = S_DONE;
               end else begin
                  res_status_in = STAT_OK;
                  state_in      = S_MUL;
               end
            end
         end
         S_MUL: begin
            // multiply into prod, fold the previous product in
            prod_in = mul_prod;
            step_in = step_ff + 2'd1;
            unique case (step_ff)
               2'd0: ;
               2'd1: n_in = prod_trunc;
               2'd2: begin
                  if (opcode_ff == OP_ADD) begin
                     n_in = n_ff + prod_trunc;
                  end else if (opcode_ff == OP_SUB) begin
                     n_in = n_ff - prod_trunc;
                  end
               end
               default: begin
                  d_in     = prod_trunc;
                  state_in = S_PREP;
               end
            endcase
         end
         S_PREP: begin
            if (n_ff == '0) begin
               res_num_in    = '0;
               res_den_in    = RES_DEN_WIDTH'(1);
               res_status_in = STAT_OK;
               state_in      = S_DONE;
            end else begin
               neg_in   = n_ff[NUM_WIDTH-1] ^ d_ff[NUM_WIDTH-1];
               mag_in   = MAG_WIDTH'(n_abs);
               dmag_in  = MAG_WIDTH'(d_abs);
               u_in     = MAG_WIDTH'(n_abs);
               v_in     = MAG_WIDTH'(d_abs);
               k_in     = '0;
               state_in = S_GCD;
            end
         end
         S_GCD: begin
            priority if (u_ff == '0) begin
               // v holds the odd part; restore the common power of two
               v_in       = v_ff << k_ff;
               rem_in     = '0;
               quo_in     = mag_ff;
               div_cnt_in = '0;
               div_sel_in = 1'b0;
               state_in   = S_DIV;
            end else if (!u_ff[0] && !v_ff[0]) begin
               u_in = u_ff >> 1;
               v_in = v_ff >> 1;
               k_in = k_ff + SHIFT_WIDTH'(1);
            end else if (!u_ff[0]) begin
               u_in = u_ff >> 1;
            end else if (!v_ff[0]) begin
               v_in = v_ff >> 1;
            end else if (u_ge_v) begin
               u_in = sub_res[MAG_WIDTH:1];
            end else begin
               v_in = sub_res[MAG_WIDTH:1];
            end
         end
         S_DIV: begin
            rem_in     = borrow ? sub_a[MAG_WIDTH-1:0] : sub_res[MAG_WIDTH-1:0];
            quo_in     = quo_next;
            div_cnt_in = div_cnt_ff + COUNT_WIDTH'(1);
            if (div_cnt_ff == COUNT_WIDTH'(MAG_WIDTH - 1)) begin
               if (!div_sel_ff) begin
                  // numerator done; start on the denominator
                  qnum_in    = quo_next;
                  rem_in     = '0;
                  quo_in     = dmag_ff;
                  div_cnt_in = '0;
                  div_sel_in = 1'b1;
               end else begin
                  res_num_in    = RES_NUM_WIDTH'(qnum_sgn);
                  res_den_in    = RES_DEN_WIDTH'(quo_next);
                  res_status_in = STAT_OK;
                  state_in      = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_num_in    = res_num_ff;
               rsp_den_in    = res_den_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      opcode_ff     <= opcode_in;
      num_a_ff      <= num_a_in;
      den_a_ff      <= den_a_in;
      num_b_ff      <= num_b_in;
      den_b_ff      <= den_b_in;
      step_ff       <= step_in;
      prod_ff       <= prod_in;
      n_ff          <= n_in;
      d_ff          <= d_in;
      neg_ff        <= neg_in;
      mag_ff        <= mag_in;
      dmag_ff       <= dmag_in;
      u_ff          <= u_in;
      v_ff          <= v_in;
      k_ff          <= k_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      qnum_ff       <= qnum_in;
      div_cnt_ff    <= div_cnt_in;
      div_sel_ff    <= div_sel_in;
      res_num_ff    <= res_num_in;
      res_den_ff    <= res_den_in;
      res_status_ff <= res_status_in;
      rsp_num_ff    <= rsp_num_in;
      rsp_den_ff    <= rsp_den_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule
